// ===== hdl/ocp_pkg.sv =====
// shared types and constants for the optimal partition changepoint unit
// no dependencies
package ocp_pkg;

   localparam int COST_BITS = 56;
   localparam int INDEX_BITS = 6;
   localparam int PENALTY_BITS = 40;
   localparam int SAMPLE_W = 16;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       is_last;
   } req_payload_type;

   typedef struct packed {
      logic                          kind;
      logic [INDEX_BITS-1:0]         index;
      logic signed [COST_BITS-1:0]   cost;
      logic [INDEX_BITS-1:0]         segment_end;
      logic                          last;
   } rsp_payload_type;

   localparam logic KIND_COST = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_RD    = 11'b00000000010,
      S_SQ    = 11'b00000000100,
      S_DIVGO = 11'b00000001000,
      S_DIV   = 11'b00000010000,
      S_ACC   = 11'b00000100000,
      S_FIN   = 11'b00001000000,
      S_PUSH  = 11'b00010000000,
      S_TWAIT = 11'b00100000000,
      S_POPRD = 11'b01000000000,
      S_POPEM = 11'b10000000000
   } state_type;

endpackage

// ===== hdl/ocp_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// no dependencies
module ocp_div #(
   parameter int DW = 70,
   parameter int LW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [DW-1:0] dividend,
   input  logic [LW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CNTW = $clog2(DW + 1);

   logic [DW-1:0]   q_ff, q_in;
   logic [LW-1:0]   rem_ff, rem_in;
   logic [LW-1:0]   dvs_ff, dvs_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [LW:0]     rem_sh;
   logic            fits;

   always_comb begin
      rem_sh = {rem_ff, q_ff[DW-1]};
      fits = rem_sh >= {1'b0, dvs_ff};
      q_in = q_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (go) begin
         q_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNTW'(DW);
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in = {q_ff[DW-2:0], fits};
         rem_in = fits ? LW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[LW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule

// ===== hdl/optimal_partition_changepoint_unit.sv =====
// top level: prefix-cost optimal partitioning with traceback
// depends on ocp_pkg and ocp_div
// each sample tries every candidate split a from 0 to t-1 in turn through the one shared
// bit-serial divider, so the work per sample grows with its position t
// a run's last sample also walks the traceback and emits every segment end
// busy stays high while a sample is worked on; results are one-cycle strobes, no stall
// synchronous reset clears control state; the sample stores are not cleared
module optimal_partition_changepoint_unit #(
   parameter int MAX_SAMPLES = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ocp_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   output ocp_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_we,
   input  logic [ocp_pkg::PENALTY_BITS-1:0]  csr_wdata
);
   localparam int SAMPLE_BITS = ocp_pkg::SAMPLE_W;
   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int RW = SAMPLE_BITS + 6;
   localparam int MB = SAMPLE_BITS + 5;
   localparam int DW = 2 * MB + FRAC_BITS;
   localparam int QW = (DW > 57) ? DW : 57;
   localparam int CB = ocp_pkg::COST_BITS;
   localparam int IB = ocp_pkg::INDEX_BITS;
   localparam logic signed [CB+1:0] HI = (CB+2)'((58'sd1 <<< (CB-1)) - 58'sd1);
   localparam logic signed [CB+1:0] LO = -(CB+2)'(58'sd1 <<< (CB-1));

   ocp_pkg::state_type state_ff, state_in;

   logic [ocp_pkg::PENALTY_BITS-1:0] pen_ff;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic signed [RW-1:0] rt_ff, rt_in;
   logic [CW-1:0]       t_ff, t_in;
   logic [CW-1:0]       a_ff, a_in;
   logic                end_ff, end_in;
   logic signed [CB-1:0] best_ff, best_in;
   logic [CW-1:0]       split_ff, split_in;
   logic signed [CB-1:0] base_ff, base_in;
   logic [2*MB-1:0]     sq_ff, sq_in;
   logic [CW-1:0]       len_ff, len_in;
   logic [CW-1:0]       p_ff, p_in;
   logic [CW-1:0]       depth_ff, depth_in;
   logic                rv_ff, rv_in;
   ocp_pkg::rsp_payload_type rp_ff, rp_in;

   logic signed [RW-1:0] prefix_mem [MAX_SAMPLES];
   logic signed [CB-1:0] best_mem [MAX_SAMPLES];
   logic [CW-1:0]       split_mem [MAX_SAMPLES];
   logic [CW-1:0]       stack_mem [MAX_SAMPLES];
   logic signed [RW-1:0] prefix_rd;
   logic signed [CB-1:0] best_rd;
   logic [CW-1:0]       split_rd, stack_rd;

   logic                pw, bw, sw, kw;
   logic [AW-1:0]       pw_a, bsw_a, rd_a, srd_a, kw_a, krd_a;

   logic                div_go, div_done;
   logic [DW-1:0]       div_q;

   logic [SAMPLE_BITS+15:0] samp_z;
   logic [SAMPLE_BITS-1:0]  samp;
   logic signed [RW-1:0]    xs, diff;
   logic [MB-1:0]           mag_in;
   logic [QW-1:0]           q_ext;
   logic [CB-1:0]           seg_mag;
   logic signed [CB+1:0]    sum_b, sum_c;
   logic signed [CB-1:0]    cand;

   ocp_div #(.DW(DW), .LW(CW)) u_div (
      .clock(clock), .reset(reset), .go(div_go),
      .dividend(DW'(sq_ff) << FRAC_BITS), .divisor(len_ff),
      .done(div_done), .quotient(div_q)
   );

   always_comb begin
      samp_z = {SAMPLE_BITS'(0), req_payload.sample};
      samp = samp_z[SAMPLE_BITS-1:0];
      xs = {{(RW-SAMPLE_BITS){samp[SAMPLE_BITS-1]}}, samp};
      diff = (a_ff == '0) ? rt_ff : RW'(rt_ff - prefix_rd);
      mag_in = diff[RW-1] ? MB'(-diff) : MB'(diff);
      sum_b = (CB+2)'(best_rd) + (CB+2)'({1'b0, pen_ff});
      q_ext = QW'(div_q);
      seg_mag = (q_ext > (QW'(1) << (CB-1))) ? (CB'(1) << (CB-1)) : CB'(q_ext);
      sum_c = (CB+2)'(base_ff) - (CB+2)'({1'b0, seg_mag});
      cand = (sum_c > HI) ? CB'(HI) : (sum_c < LO) ? CB'(LO) : CB'(sum_c);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rt_in = rt_ff;
      t_in = t_ff;
      a_in = a_ff;
      end_in = end_ff;
      best_in = best_ff;
      split_in = split_ff;
      base_in = base_ff;
      sq_in = sq_ff;
      len_in = len_ff;
      p_in = p_ff;
      depth_in = depth_ff;
      rv_in = 1'b0;
      rp_in = rp_ff;
      pw = 1'b0; bw = 1'b0; sw = 1'b0; kw = 1'b0;
      pw_a = cnt_ff[AW-1:0];
      bsw_a = AW'(t_ff - 1'b1);
      rd_a = AW'(a_ff - 1'b1);
      srd_a = AW'(p_ff - 1'b1);
      kw_a = depth_ff[AW-1:0];
      krd_a = AW'(depth_ff - 1'b1);
      div_go = 1'b0;
      unique case (state_ff)
         ocp_pkg::S_IDLE: begin
            if (start) begin
               rt_in = RW'(rt_ff + xs);
               pw = 1'b1;
               t_in = cnt_ff + 1'b1;
               end_in = req_payload.is_last || (cnt_ff + 1'b1 == CW'(MAX_SAMPLES));
               a_in = '0;
               state_in = ocp_pkg::S_SQ;
            end
         end
         ocp_pkg::S_RD: state_in = ocp_pkg::S_SQ;
         ocp_pkg::S_SQ: begin
            sq_in = mag_in * mag_in;
            len_in = t_ff - a_ff;
            if (a_ff == '0) begin
               base_in = '0;
            end else begin
               base_in = (sum_b > HI) ? CB'(HI) : CB'(sum_b);
            end
            state_in = ocp_pkg::S_DIVGO;
         end
         ocp_pkg::S_DIVGO: begin
            div_go = 1'b1;
            state_in = ocp_pkg::S_DIV;
         end
         ocp_pkg::S_DIV: if (div_done) state_in = ocp_pkg::S_ACC;
         ocp_pkg::S_ACC: begin
            if (a_ff == '0 || cand <= best_ff) begin
               best_in = cand;
               split_in = a_ff;
            end
            a_in = a_ff + 1'b1;
            state_in = (a_ff + 1'b1 < t_ff) ? ocp_pkg::S_RD : ocp_pkg::S_FIN;
         end
         ocp_pkg::S_FIN: begin
            bw = 1'b1;
            sw = 1'b1;
            rv_in = 1'b1;
            rp_in.kind = ocp_pkg::KIND_COST;
            rp_in.index = IB'(t_ff);
            rp_in.cost = best_ff;
            rp_in.segment_end = '0;
            rp_in.last = 1'b0;
            cnt_in = t_ff;
            p_in = split_ff;
            depth_in = '0;
            state_in = end_ff ? ocp_pkg::S_PUSH : ocp_pkg::S_IDLE;
         end
         ocp_pkg::S_PUSH: begin
            if (p_ff == '0) begin
               state_in = ocp_pkg::S_POPRD;
            end else begin
               kw = 1'b1;
               depth_in = depth_ff + 1'b1;
               state_in = ocp_pkg::S_TWAIT;
            end
         end
         ocp_pkg::S_TWAIT: begin
            p_in = split_rd;
            state_in = ocp_pkg::S_PUSH;
         end
         ocp_pkg::S_POPRD: begin
            if (depth_ff == '0) begin
               rv_in = 1'b1;
               rp_in.kind = ocp_pkg::KIND_END;
               rp_in.index = '0;
               rp_in.cost = '0;
               rp_in.segment_end = IB'(t_ff);
               rp_in.last = 1'b1;
               cnt_in = '0;
               rt_in = '0;
               state_in = ocp_pkg::S_IDLE;
            end else begin
               depth_in = depth_ff - 1'b1;
               state_in = ocp_pkg::S_POPEM;
            end
         end
         ocp_pkg::S_POPEM: begin
            rv_in = 1'b1;
            rp_in.kind = ocp_pkg::KIND_END;
            rp_in.index = '0;
            rp_in.cost = '0;
            rp_in.segment_end = IB'(stack_rd);
            rp_in.last = 1'b0;
            state_in = ocp_pkg::S_POPRD;
         end
         default: state_in = ocp_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pw) prefix_mem[pw_a] <= rt_in;
      prefix_rd <= prefix_mem[rd_a];
   end

   always_ff @(posedge clock) begin
      if (bw) best_mem[bsw_a] <= best_ff;
      best_rd <= best_mem[rd_a];
   end

   always_ff @(posedge clock) begin
      if (sw) split_mem[bsw_a] <= split_ff;
      split_rd <= split_mem[srd_a];
   end

   always_ff @(posedge clock) begin
      if (kw) stack_mem[kw_a] <= p_ff;
      stack_rd <= stack_mem[krd_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ocp_pkg::S_IDLE;
         pen_ff <= '0;
         cnt_ff <= '0;
         rt_ff <= '0;
         depth_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) pen_ff <= csr_wdata;
         cnt_ff <= cnt_in;
         rt_ff <= rt_in;
         depth_ff <= depth_in;
         rv_ff <= rv_in;
      end
      t_ff <= t_in;
      a_ff <= a_in;
      end_ff <= end_in;
      best_ff <= best_in;
      split_ff <= split_in;
      base_ff <= base_in;
      sq_ff <= sq_in;
      len_ff <= len_in;
      p_ff <= p_in;
      rp_ff <= rp_in;
   end

   assign busy = (state_ff != ocp_pkg::S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_payload = rp_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ocp_pkg::S_DIV)
      else $error("divider finished outside its wait state");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == ocp_pkg::S_SQ)
      else $error("accepted transaction did not begin its scan");

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.last) |-> rsp_payload.kind == ocp_pkg::KIND_END)
      else $error("final transaction is not a segment end");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CW'(MAX_SAMPLES))
      else $error("traceback stack overflow");

   a_resp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) != ocp_pkg::S_IDLE)
      else $error("response strobe without work in progress");
endmodule

// ===== bench/tb_top.sv =====
// testbench for optimal_partition_changepoint_unit: directed table then random sample runs,
// every transaction checked against a behavioral partition-cost predictor
// depends on ocp_pkg and the unit under test
module tb_top;

   localparam int MAX_SAMPLES = 32;
   localparam int FRAC_BITS = 8;
   localparam int RANDOM_ITEMS = 230;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam longint COST_MAX = 64'sd36028797018963967;
   localparam longint COST_MIN = -64'sd36028797018963968;
   localparam longint PENALTY_MAX = 64'hFF_FFFF_FFFF;

   typedef struct {
      logic signed [15:0] sample;
      logic               is_last;
      bit                 typed;
      longint             cost;
   } dir_row_type;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   ocp_pkg::req_payload_type         req_payload;
   logic                             rsp_valid;
   ocp_pkg::rsp_payload_type         rsp_payload;
   logic                             csr_we;
   logic [ocp_pkg::PENALTY_BITS-1:0] csr_wdata;

   ocp_pkg::rsp_payload_type expected_results[$];
   longint          cycle_count;
   int              mismatch_count;

   longint penalty_mirror;
   int     run_length;
   longint run_total;
   longint prefix_sums[MAX_SAMPLES];
   longint best_costs[MAX_SAMPLES];
   int     best_splits[MAX_SAMPLES];

   dir_row_type dir_rows[21] = '{
      '{16'sd0, 1'b1, 1'b1, 0},
      '{-16'sd32768, 1'b1, 1'b1, -64'sd274877906944},
      '{16'sd32767, 1'b1, 1'b1, -64'sd274861129984},
      '{16'sd1, 1'b1, 1'b1, -64'sd256},
      '{16'sd100, 1'b0, 1'b0, 0},
      '{-16'sd100, 1'b1, 1'b0, 0},
      '{16'sd1000, 1'b0, 1'b0, 0},
      '{16'sd1000, 1'b0, 1'b0, 0},
      '{16'sd1000, 1'b0, 1'b0, 0},
      '{-16'sd1000, 1'b0, 1'b0, 0},
      '{-16'sd1000, 1'b0, 1'b0, 0},
      '{-16'sd1000, 1'b1, 1'b0, 0},
      '{16'sd5, 1'b0, 1'b0, 0},
      '{16'sd5, 1'b0, 1'b0, 0},
      '{16'sd30000, 1'b0, 1'b0, 0},
      '{16'sd30000, 1'b1, 1'b0, 0},
      '{-16'sd1, 1'b0, 1'b0, 0},
      '{-16'sd1, 1'b1, 1'b0, 0},
      '{16'sd0, 1'b0, 1'b0, 0},
      '{16'sd0, 1'b0, 1'b0, 0},
      '{16'sd0, 1'b1, 1'b0, 0}
   };

   optimal_partition_changepoint_unit DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > COST_MAX) return COST_MAX;
      if (s < COST_MIN) return COST_MIN;
      return s;
   endfunction

   function automatic longint segment_cost(longint sum, int len);
      longint mag_in;
      longint sq;
      longint quo;
      longint rem;
      longint mag;
      mag_in = (sum < 0) ? -sum : sum;
      sq = mag_in * mag_in;
      quo = sq / len;
      rem = sq % len;
      if (quo > (COST_MAX + 1) >>> FRAC_BITS) begin
         mag = COST_MAX + 1;
      end else begin
         mag = (quo <<< FRAC_BITS) + ((rem <<< FRAC_BITS) / len);
         if (mag > COST_MAX + 1) mag = COST_MAX + 1;
      end
      return -mag;
   endfunction

   // returns the index of the cost expectation just pushed
   function automatic int predict_partition(logic signed [15:0] sample, logic is_last);
      int pos;
      int t;
      int split;
      int p;
      int depth;
      int trace[MAX_SAMPLES];
      longint best;
      longint c;
      ocp_pkg::rsp_payload_type r;
      int cost_slot;
      pos = (run_length >= MAX_SAMPLES) ? 0 : run_length;
      run_total += longint'(sample);
      prefix_sums[pos] = run_total;
      t = pos + 1;
      best = segment_cost(run_total, t);
      split = 0;
      for (int a = 1; a < t; a++) begin
         c = sat_add(best_costs[a-1], penalty_mirror);
         c = sat_add(c, segment_cost(run_total - prefix_sums[a-1], t - a));
         if (c <= best) begin
            best = c;
            split = a;
         end
      end
      best_costs[pos] = best;
      best_splits[pos] = split;
      run_length = t;
      r = '0;
      r.kind = ocp_pkg::KIND_COST;
      r.index = t[ocp_pkg::INDEX_BITS-1:0];
      r.cost = best[ocp_pkg::COST_BITS-1:0];
      expected_results.push_back(r);
      cost_slot = expected_results.size() - 1;
      if (is_last || t >= MAX_SAMPLES) begin
         depth = 0;
         p = best_splits[t-1];
         while (p > 0 && depth < MAX_SAMPLES) begin
            trace[depth] = p;
            depth++;
            p = best_splits[p-1];
         end
         while (depth > 0) begin
            depth--;
            r = '0;
            r.kind = ocp_pkg::KIND_END;
            r.segment_end = trace[depth][ocp_pkg::INDEX_BITS-1:0];
            expected_results.push_back(r);
         end
         r = '0;
         r.kind = ocp_pkg::KIND_END;
         r.segment_end = t[ocp_pkg::INDEX_BITS-1:0];
         r.last = 1'b1;
         expected_results.push_back(r);
         run_length = 0;
         run_total = 0;
      end
      return cost_slot;
   endfunction

   // caller is at a rising edge; returns at the edge that accepts the transaction
   task automatic send_sample(logic signed [15:0] sample, logic is_last, output int slot);
      ocp_pkg::req_payload_type p;
      p.sample = sample;
      p.is_last = is_last;
      start <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (busy);
      slot = predict_partition(sample, is_last);
   endtask

   task automatic drain_and_idle();
      start <= 1'b0;
      while (expected_results.size() != 0 || busy) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_penalty(longint value);
      csr_we <= 1'b1;
      csr_wdata <= value[ocp_pkg::PENALTY_BITS-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      penalty_mirror = value & PENALTY_MAX;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: %p", rsp_payload);
         end else begin
            if (rsp_payload !== expected_results[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", expected_results[0], rsp_payload);
            end
            void'(expected_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int slot;
      int sent;
      int burst_left;
      int len;
      int phase;
      logic signed [15:0] level;
      logic signed [15:0] value;
      logic last_flag;
      longint phase_penalty[5];
      cycle_count = 0;
      mismatch_count = 0;
      run_length = 0;
      run_total = 0;
      penalty_mirror = 0;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_penalty(0);
      foreach (dir_rows[i]) begin
         send_sample(dir_rows[i].sample, dir_rows[i].is_last, slot);
         if (dir_rows[i].typed)
            expected_results[slot].cost = dir_rows[i].cost[ocp_pkg::COST_BITS-1:0];
      end
      drain_and_idle();

      phase_penalty[0] = PENALTY_MAX;
      phase_penalty[1] = 256 * 40000;
      phase_penalty[2] = 0;
      phase_penalty[3] = {$urandom, $urandom} & PENALTY_MAX;
      phase_penalty[4] = 256 * $urandom_range(1, 4000000);
      sent = 0;
      burst_left = 0;
      for (phase = 0; phase < 5; phase++) begin
         write_penalty(phase_penalty[phase]);
         while (sent < RANDOM_ITEMS * (phase + 1) / 5) begin
            len = ($urandom_range(0, 9) == 0) ? MAX_SAMPLES : $urandom_range(1, 8);
            level = 16'($urandom);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 5) == 0) level = 16'($urandom);
               value = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : level + 16'($urandom_range(0, 64)) - 16'sd32;
               last_flag = (k == len - 1) ? ((len == MAX_SAMPLES) ? 1'($urandom) : 1'b1) : 1'b0;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 8);
                  if ($urandom_range(0, 2) != 0) begin
                     start <= 1'b0;
                     repeat ($urandom_range(1, 20)) @(posedge clock);
                  end
               end
               burst_left--;
               send_sample(value, last_flag, slot);
               sent++;
            end
         end
         drain_and_idle();
      end

      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
